FILE: hw/rtl/mspt_pkg.sv
// ----------------------------------------------------------------------------
// mspt_pkg
// shared constants, codes and types of the multi-slot periodic timer
// ----------------------------------------------------------------------------
package mspt_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PERIOD_W    = 26;
    localparam int REM_W       = 27;
    localparam int RATE_W      = 16;
    localparam int HANDLE_W    = 16;
    localparam int KIND_W      = 2;

    localparam logic [PERIOD_W-1:0] TICK_PERIOD = PERIOD_W'(54925);
    localparam logic [PERIOD_W-1:0] MS_TO_US    = PERIOD_W'(1000);

    // request types
    localparam logic [KIND_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] REQ_CREATE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_KILL   = 2'd2;

    // reply kinds
    localparam logic [KIND_W-1:0] REP_FIRED  = 2'd0;
    localparam logic [KIND_W-1:0] REP_CREATE = 2'd1;
    localparam logic [KIND_W-1:0] REP_KILL   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] value;
        logic                last;
    } res_t;

endpackage

FILE: hw/rtl/mspt_alu.sv
// ----------------------------------------------------------------------------
// mspt_alu
// shared add/subtract unit for the slot counters, with a due flag
// ----------------------------------------------------------------------------
module mspt_alu
    import mspt_pkg::*;
(
    input  logic [REM_W-1:0] a,
    input  logic [REM_W-1:0] b,
    input  logic             sub,
    output logic [REM_W-1:0] y,
    output logic             le_zero
);

    assign y       = sub ? (a - b) : (a + b);
    assign le_zero = y[REM_W-1] || (y == '0);

endmodule

FILE: hw/rtl/mspt_core.sv
// ----------------------------------------------------------------------------
// mspt_core
// slot table and sequencer: the slots pass one after another through the shared unit
// ----------------------------------------------------------------------------
module mspt_core
    import mspt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                timers_disabled,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [KIND_W-1:0]   req_type,
    input  logic [RATE_W-1:0]   rate_ms,
    input  logic [HANDLE_W-1:0] timer_handle,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUB   = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_REPLY = 3'd4;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    logic [2:0]           state_reg, state_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] fire_reg, fire_next;
    res_t                 reply_reg, reply_next;

    logic [PERIOD_W-1:0]  period_reg [NUM_SLOTS];
    logic [REM_W-1:0]     rem_reg [NUM_SLOTS];

    logic                 tbl_we;
    logic [SLOT_W-1:0]    tbl_idx;
    logic                 period_we;
    logic [PERIOD_W-1:0]  period_wdata;
    logic [REM_W-1:0]     rem_wdata;

    logic [REM_W-1:0]     alu_a, alu_b, alu_y;
    logic                 alu_sub, alu_le;

    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
    logic [PERIOD_W-1:0]  prod;
    logic [PERIOD_W-1:0]  new_period;
    logic [HANDLE_W-1:0]  handle_m1;
    logic                 kill_ok;
    logic [NUM_SLOTS-1:0] fire_clr;
    logic [HANDLE_W-1:0]  idx_handle;

    mspt_alu u_alu (
        .a       (alu_a),
        .b       (alu_b),
        .sub     (alu_sub),
        .y       (alu_y),
        .le_zero (alu_le)
    );

    // first free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign prod       = PERIOD_W'(rate_ms) * MS_TO_US;
    assign new_period = (prod < TICK_PERIOD) ? TICK_PERIOD : prod;
    assign handle_m1  = timer_handle - HANDLE_W'(1);
    assign kill_ok    = (timer_handle != '0)
                     && (timer_handle <= HANDLE_W'(NUM_SLOTS))
                     && active_reg[handle_m1[SLOT_W-1:0]];
    assign idx_handle = HANDLE_W'(idx_reg) + HANDLE_W'(1);
    assign fire_clr   = fire_reg & ~(NUM_SLOTS'(1) << idx_reg);

    assign alu_a   = rem_reg[idx_reg];
    assign alu_sub = (state_reg == ST_SUB);
    assign alu_b   = alu_sub ? REM_W'(TICK_PERIOD) : {1'b0, period_reg[idx_reg]};

    assign req_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        active_next  = active_reg;
        fire_next    = fire_reg;
        reply_next   = reply_reg;
        tbl_we       = 1'b0;
        tbl_idx      = idx_reg;
        period_we    = 1'b0;
        period_wdata = new_period;
        rem_wdata    = alu_y;
        res_valid    = 1'b0;
        res          = reply_reg;

        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    case (req_type)
                        REQ_TICK: begin
                            if (!timers_disabled) begin
                                idx_next   = '0;
                                fire_next  = '0;
                                state_next = ST_SUB;
                            end
                        end
                        REQ_CREATE: begin
                            reply_next.kind  = REP_CREATE;
                            reply_next.value = '0;
                            reply_next.last  = 1'b1;
                            if (free_found) begin
                                tbl_we                = 1'b1;
                                period_we             = 1'b1;
                                tbl_idx               = free_idx;
                                rem_wdata             = {1'b0, new_period};
                                active_next[free_idx] = 1'b1;
                                reply_next.value      = HANDLE_W'(free_idx) + HANDLE_W'(1);
                            end
                            state_next = ST_REPLY;
                        end
                        REQ_KILL: begin
                            reply_next.kind  = REP_KILL;
                            reply_next.value = timer_handle;
                            reply_next.last  = 1'b1;
                            if (kill_ok) begin
                                active_next[handle_m1[SLOT_W-1:0]] = 1'b0;
                                reply_next.value = '0;
                            end
                            state_next = ST_REPLY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SUB, ST_ADD: begin
                if (state_reg == ST_ADD || active_reg[idx_reg]) begin
                    tbl_we = 1'b1;
                end
                if (state_reg == ST_SUB && active_reg[idx_reg] && alu_le) begin
                    state_next = ST_ADD;
                end else begin
                    if (state_reg == ST_ADD) begin
                        fire_next[idx_reg] = 1'b1;
                    end
                    state_next = ST_SUB;
                    if (idx_reg == LAST_IDX) begin
                        idx_next = '0;
                        if (fire_next == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end else begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                res.kind  = REP_FIRED;
                res.value = idx_handle;
                res.last  = (fire_clr == '0);
                if (fire_reg[idx_reg]) begin
                    res_valid = 1'b1;
                    if (res_ready) begin
                        fire_next = fire_clr;
                        if (fire_clr == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg + SLOT_W'(1);
                        end
                    end
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_REPLY: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            active_reg <= '0;
            fire_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            fire_reg   <= fire_next;
        end
    end

    always_ff @(posedge aclk) begin
        reply_reg <= reply_next;
        if (tbl_we) begin
            rem_reg[tbl_idx] <= rem_wdata;
        end
        if (period_we) begin
            period_reg[tbl_idx] <= period_wdata;
        end
    end

endmodule

FILE: hw/rtl/multi_slot_periodic_timer.sv
// replies: create and kill replies are registered in the core, then again in the output register
// tick: each slot takes a subtract step through the shared add/subtract unit, and an add
//   step when it is active and due, then an emit pass walks the slots up to the last one fired
// throughput: one request at a time, the sequencer holds s_tready low until done;
//   unused requests and ticks while disabled are taken from idle and give no reply
// reset: aresetn synchronous active low, clears all slots and timers_disabled
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer
// table of periodic timer slots with create, kill and tick requests
// ----------------------------------------------------------------------------
module multi_slot_periodic_timer
    import mspt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // timers_disabled
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // rate_ms[15:0], timer_handle[31:16]
    input  logic [1:0]  s_tuser,       // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // reply_value[15:0]
    output logic [1:0]  m_tuser,       // reply_kind[1:0]
    output logic        m_tlast        // last_of_run
);

    logic disabled_reg;
    logic m_valid_reg;
    res_t out_reg;
    logic res_valid;
    logic res_ready;
    res_t res;

    assign res_ready = !m_valid_reg || m_tready;

    mspt_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .timers_disabled (disabled_reg),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_type        (s_tuser),
        .rate_ms         (s_tdata[15:0]),
        .timer_handle    (s_tdata[31:16]),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disabled_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                disabled_reg <= cfg_wdata;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg.value;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

FILE: tb/sv/mspt_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_reply_checker
// watches the request and reply streams of the periodic timer, keeps its own
// slot table and register copy, and checks every reply in order
// ----------------------------------------------------------------------------
module mspt_reply_checker
    import mspt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);

    logic                       timers_off;
    logic                       slot_on   [NUM_SLOTS];
    logic [PERIOD_W-1:0]        slot_per  [NUM_SLOTS];
    logic signed [REM_W-1:0]    slot_left [NUM_SLOTS];
    res_t                       due_replies[$];
    int                         errs = 0;

    // advance the slot table by one request and queue the replies it causes
    task automatic predict_replies(input logic [KIND_W-1:0] req,
                                   input logic [RATE_W-1:0] rate,
                                   input logic [HANDLE_W-1:0] handle);
        res_t r;
        int   n0;
        int   left;
        int   per;
        int   idx;
        bit   placed;
        n0 = due_replies.size();
        case (req)
            REQ_TICK: begin
                if (!timers_off) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_on[i]) begin
                            left = int'(slot_left[i]) - int'(TICK_PERIOD);
                            if (left <= 0) begin
                                left = left + int'(slot_per[i]);
                                r.kind = REP_FIRED;
                                r.value = HANDLE_W'(i + 1);
                                r.last = 1'b0;
                                due_replies.push_back(r);
                            end
                            slot_left[i] = REM_W'(left);
                        end
                    end
                end
            end
            REQ_CREATE: begin
                r.kind = REP_CREATE;
                r.value = '0;
                r.last = 1'b0;
                placed = 0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!placed && !slot_on[i]) begin
                        per = int'(rate) * int'(MS_TO_US);
                        if (per < int'(TICK_PERIOD))
                            per = int'(TICK_PERIOD);
                        slot_per[i] = PERIOD_W'(per);
                        slot_left[i] = REM_W'(per);
                        slot_on[i] = 1'b1;
                        r.value = HANDLE_W'(i + 1);
                        placed = 1;
                    end
                end
                due_replies.push_back(r);
            end
            REQ_KILL: begin
                r.kind = REP_KILL;
                r.value = handle;
                r.last = 1'b0;
                idx = int'(handle) - 1;
                if (handle != 0 && int'(handle) <= NUM_SLOTS) begin
                    if (slot_on[idx]) begin
                        slot_on[idx] = 1'b0;
                        r.value = '0;
                    end
                end
                due_replies.push_back(r);
            end
            default: ;
        endcase
        if (due_replies.size() > n0) begin
            r = due_replies.pop_back();
            r.last = 1'b1;
            due_replies.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            timers_off = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
                slot_on[i] = 1'b0;
            due_replies.delete();
        end else begin
            if (cfg_we)
                timers_off = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_replies(s_tuser, s_tdata[15:0], s_tdata[31:16]);
            if (m_tvalid && m_tready) begin
                if (due_replies.size() == 0) begin
                    $error("reply with none expected: reply_kind %0d reply_value %0d",
                           m_tuser, m_tdata);
                    errs++;
                end else begin
                    want = due_replies.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("reply_kind expected %0d actual %0d", want.kind, m_tuser);
                        errs++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("reply_value expected %0d actual %0d", want.value, m_tdata);
                        errs++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run expected %0d actual %0d", want.last, m_tlast);
                        errs++;
                    end
                end
            end
        end
        fail_count <= errs;
        pending_count <= due_replies.size();
    end

endmodule

FILE: tb/sv/multi_slot_periodic_timer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer_test
// drives create, kill and tick requests into the periodic timer under
// several idle and stall patterns and register settings; the reply checker
// beside the block predicts and compares every reply
// ----------------------------------------------------------------------------
module multi_slot_periodic_timer_test;
    import mspt_pkg::*;

    localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    multi_slot_periodic_timer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mspt_reply_checker reply_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [KIND_W-1:0] req,
                            input logic [RATE_W-1:0] rate,
                            input logic [HANDLE_W-1:0] handle);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {handle, rate};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold requests back until every pending reply is in
    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_disable(input bit v);
        drain(SETTLE_CYCLES);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [KIND_W-1:0]   req;
        logic [RATE_W-1:0]   rate;
        logic [HANDLE_W-1:0] handle;
        int                  count;
        int                  pick;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_disable(1'b0);

        // bad handles on an empty table
        send_req(REQ_KILL, 16'h0000, 16'h0000);
        send_req(REQ_KILL, 16'h0000, 16'h0001);
        send_req(REQ_KILL, 16'hffff, 16'hffff);
        // longest period, then a tick with nothing due
        send_req(REQ_CREATE, 16'hffff, 16'h0000);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        // clamp edges and fill the table
        send_req(REQ_CREATE, 16'd0, 16'h0000);
        send_req(REQ_CREATE, 16'd54, 16'h0000);
        send_req(REQ_CREATE, 16'd55, 16'h0000);
        send_req(REQ_CREATE, 16'd1, 16'h0000);
        send_req(REQ_CREATE, 16'd0, 16'h0000);
        send_req(REQ_CREATE, 16'd0, 16'h0000);
        send_req(REQ_CREATE, 16'd0, 16'h0000);
        send_req(REQ_CREATE, 16'd2, 16'h0000);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_UNUSED, 16'hffff, 16'hffff);
        // kill above range, valid, twice, and the long slot
        send_req(REQ_KILL, 16'h0000, 16'd9);
        send_req(REQ_KILL, 16'h0000, 16'd4);
        send_req(REQ_KILL, 16'h0000, 16'd4);
        send_req(REQ_KILL, 16'h0000, 16'd1);
        send_req(REQ_CREATE, 16'd0, 16'h0000);
        send_req(REQ_CREATE, 16'd0, 16'h0000);
        // all slots due at once
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        set_disable(1'b1);
        send_req(REQ_TICK, 16'h0000, 16'h0000);
        send_req(REQ_CREATE, 16'd0, 16'h0000);
        set_disable(1'b0);
        send_req(REQ_TICK, 16'h0000, 16'h0000);

        for (int phase = 0; phase < 4; phase++) begin
            drain(0);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 72; end
                default: begin send_idle_pct = 26; recv_stall_pct <= 26; end
            endcase
            set_disable(phase == 2);
            count = 0;
            while (count < PHASE_ITEMS) begin
                if (count == PHASE_ITEMS / 2)
                    set_disable(phase == 3);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    req = REQ_TICK;
                else if (pick < 70)
                    req = REQ_CREATE;
                else if (pick < 95)
                    req = REQ_KILL;
                else
                    req = REQ_UNUSED;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: rate = 16'($urandom_range(0, 200));
                    5, 6, 7: rate = 16'($urandom_range(0, 3000));
                    8: rate = 16'($urandom());
                    default: begin
                        case ($urandom_range(0, 3))
                            0: rate = 16'd0;
                            1: rate = 16'd54;
                            2: rate = 16'd55;
                            default: rate = 16'hffff;
                        endcase
                    end
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: handle = 16'($urandom_range(1, NUM_SLOTS));
                    7, 8: handle = 16'($urandom_range(0, 20));
                    default: handle = 16'($urandom());
                endcase
                send_req(req, rate, handle);
                if (req != REQ_UNUSED)
                    count++;
                if ($urandom_range(0, 59) == 0)
                    drain(0);
            end
        end

        drain(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mspt_pkg.sv
hw/rtl/mspt_alu.sv
hw/rtl/mspt_core.sv
hw/rtl/multi_slot_periodic_timer.sv
tb/sv/mspt_reply_checker.sv
tb/sv/multi_slot_periodic_timer_test.sv
